// ----- src/admin_session_sequencer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the admin session sequencer core
// Clocked, reset-qualified property checks used by the sequencer core.
// ----------------------------------------------------------------------------
`ifndef ADMIN_SESSION_SEQUENCER_CORE_ASSERT_SVH
`define ADMIN_SESSION_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define ASS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define ASS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ass_pkg.sv -----
// ----------------------------------------------------------------------------
// Admin session sequencer package
// Types and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ass_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [9:0] SEND_TIMEOUT_MS   = 10'd1000;
  localparam logic [9:0] ZERO_DLY_WINDOW_MS = 10'd30;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RX_DELAY   = 2'd0,
    CFG_RX_LENGTH  = 2'd1,
    CFG_RESP_DELAY = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_DISABLED = 3'd0,
    PH_IDLE     = 3'd1,
    PH_WAIT_RX  = 3'd2,
    PH_LISTEN   = 3'd3,
    PH_WAIT_TX  = 3'd4,
    PH_SENDING  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_SEND_DATA   = 3'd1,
    ACT_SEND_RSP    = 3'd2,
    ACT_LISTEN      = 3'd3,
    ACT_START_TIMER = 3'd4,
    ACT_STOP_TIMER  = 3'd5
  } action_e;

  typedef struct packed {
    logic evt_init;
    logic evt_close;
    logic evt_open;
    logic evt_resp_ready;
    logic evt_delay_expired;
    logic evt_recv_done;
    logic evt_send_done;
    logic evt_timeout;
    logic set_bypass;
    logic service_failed;
  } ass_in_t;

  typedef struct packed {
    logic        flag_error;
    logic        flag_complete;
    logic        flag_timeout;
    logic        flag_data_sent;
    logic        flag_rsp_sent;
    logic        flag_cmd_recv;
    logic        flag_out_date;
    logic [2:0]  action;
    logic [10:0] action_seconds;
    logic [9:0]  action_millis;
    logic [2:0]  session_state;
  } ass_out_t;

  typedef struct packed {
    logic [7:0] rx_delay;
    logic [7:0] rx_length;
    logic [7:0] resp_delay;
  } ass_cfg_t;

  typedef struct packed {
    phase_e phase;
    logic   resp_pending;
    logic   resp_ready;
    logic   skip_cmd;
  } ass_state_t;

endpackage

// ----- src/ass_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Admin session sequencer configuration registers
// Holds the receive delay, receive length and response delay settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ass_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ass_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  output ass_pkg::ass_cfg_t             cfg_o
);
  import ass_pkg::*;

  ass_cfg_t cfg_q;
  ass_cfg_t cfg_d;

  // Writes never wait.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RX_DELAY:   cfg_d.rx_delay   = cfg_data_i;
        CFG_RX_LENGTH:  cfg_d.rx_length  = cfg_data_i;
        CFG_RESP_DELAY: cfg_d.resp_delay = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/ass_step.sv -----
// ----------------------------------------------------------------------------
// Admin session sequencer step logic
// Next session state and the result beat for one event beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ass_step (
  input  ass_pkg::ass_in_t    in_i,
  input  ass_pkg::ass_state_t state_i,
  input  ass_pkg::ass_cfg_t   cfg_i,
  output ass_pkg::ass_state_t state_o,
  output ass_pkg::ass_out_t   result_o
);
  import ass_pkg::*;

  ass_state_t  st;
  phase_e      prev;
  logic        f_err, f_cmp, f_tmo, f_data, f_rsp, f_cmd, f_old;
  action_e     act;
  logic [10:0] secs;
  logic [9:0]  ms;
  logic [10:0] listen_len;

  // Five times the listen unit as a shift and add.
  assign listen_len = {1'b0, cfg_i.rx_length, 2'b00} + {3'b000, cfg_i.rx_length};

  always_comb begin
    st     = state_i;
    f_err  = 1'b0;
    f_cmp  = 1'b0;
    f_tmo  = 1'b0;
    f_data = 1'b0;
    f_rsp  = 1'b0;
    f_cmd  = 1'b0;
    f_old  = 1'b0;
    act    = ACT_NONE;
    secs   = '0;
    ms     = '0;

    if (in_i.evt_init) begin
      st.resp_pending = 1'b0;
      st.resp_ready   = 1'b0;
      st.phase        = PH_IDLE;
    end
    prev = st.phase;
    if (in_i.set_bypass) st.skip_cmd = 1'b1;

    if (in_i.evt_close) begin
      act      = ACT_STOP_TIMER;
      st.phase = PH_IDLE;
      f_cmp    = 1'b1;
    end
    if (in_i.evt_resp_ready) st.resp_ready = 1'b1;

    unique case (st.phase)
      PH_IDLE: begin
        if (in_i.evt_open) begin
          st.skip_cmd     = 1'b0;
          st.resp_pending = 1'b0;
          st.resp_ready   = 1'b0;
          act             = ACT_SEND_DATA;
          ms              = SEND_TIMEOUT_MS;
          if (in_i.service_failed) begin
            st.phase = PH_IDLE;
            f_cmp    = 1'b0;
            f_err    = 1'b1;
          end else begin
            st.phase = PH_SENDING;
          end
        end
      end
      PH_WAIT_RX: begin
        if (in_i.evt_delay_expired) begin
          if (!st.skip_cmd) begin
            act  = ACT_LISTEN;
            secs = listen_len;
            if (in_i.service_failed) begin
              st.phase = PH_IDLE;
              f_cmp    = 1'b0;
              f_err    = 1'b1;
            end else begin
              st.phase = PH_LISTEN;
            end
          end else begin
            st.phase = PH_IDLE;
          end
        end
      end
      PH_LISTEN: begin
        if (in_i.evt_recv_done) begin
          f_cmd           = 1'b1;
          st.resp_pending = 1'b1;
          st.resp_ready   = 1'b0;
          act             = ACT_START_TIMER;
          if (cfg_i.resp_delay != 8'd0) begin
            secs = {3'b000, cfg_i.resp_delay};
          end else begin
            ms = ZERO_DLY_WINDOW_MS;
          end
          if (in_i.service_failed) begin
            st.phase = PH_IDLE;
            f_cmp    = 1'b0;
            f_cmd    = 1'b0;
            f_err    = 1'b1;
          end else begin
            st.phase = PH_WAIT_TX;
          end
        end
        // A failed timer start ends the step before the timeout is seen.
        if (in_i.evt_timeout && !(in_i.evt_recv_done && in_i.service_failed)) begin
          st.phase = PH_IDLE;
          f_tmo    = 1'b1;
        end
      end
      PH_WAIT_TX: begin
        if (in_i.evt_delay_expired) begin
          if (st.resp_ready) begin
            act = ACT_SEND_RSP;
            ms  = SEND_TIMEOUT_MS;
            if (in_i.service_failed) begin
              st.phase = PH_IDLE;
              f_cmp    = 1'b0;
              f_err    = 1'b1;
            end else begin
              st.phase = PH_SENDING;
            end
          end else begin
            st.phase = PH_IDLE;
            f_old    = 1'b1;
          end
        end
      end
      PH_SENDING: begin
        if (in_i.evt_send_done) begin
          if (st.resp_pending) begin
            st.phase        = PH_IDLE;
            st.resp_pending = 1'b0;
            st.resp_ready   = 1'b0;
            f_rsp           = 1'b1;
          end else begin
            if (!st.skip_cmd) begin
              act  = ACT_START_TIMER;
              secs = {3'b000, cfg_i.rx_delay};
              if (in_i.service_failed) begin
                st.phase = PH_IDLE;
                f_cmp    = 1'b0;
                f_err    = 1'b1;
              end else begin
                st.phase = PH_WAIT_RX;
              end
            end else begin
              st.phase = PH_IDLE;
            end
            f_data = 1'b1;
          end
        end
        if (in_i.evt_timeout) begin
          st.phase = PH_IDLE;
          f_tmo    = 1'b1;
        end
      end
      default: begin
        // Disabled and the unused codes ignore everything but init and close.
      end
    endcase

    if ((st.phase != prev) && (st.phase == PH_IDLE)) f_cmp = 1'b1;
  end

  assign state_o = st;

  always_comb begin
    result_o.flag_error     = f_err;
    result_o.flag_complete  = f_cmp;
    result_o.flag_timeout   = f_tmo;
    result_o.flag_data_sent = f_data;
    result_o.flag_rsp_sent  = f_rsp;
    result_o.flag_cmd_recv  = f_cmd;
    result_o.flag_out_date  = f_old;
    result_o.action         = act;
    result_o.action_seconds = secs;
    result_o.action_millis  = ms;
    result_o.session_state  = st.phase;
  end

endmodule

// ----- src/admin_session_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Admin session sequencer core
// Event-driven sequencer of a radio administration session: one result beat
// with status flags and a service request for every event beat.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                  | Beat
//  --------+-----------+----------------------------+---------------------
//  in      | input     | in_valid_i / in_stall_o    | ass_in_t events
//  out     | output    | out_valid_o / out_stall_i  | ass_out_t result
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | index + 8-bit data
//
// Each event beat yields exactly one result beat, held first in the input
// register and then in the result register. One beat is taken per cycle while
// the output does not stall, set by the single step of logic between the two.
// Reset disables the session, clears the pending, ready and bypass marks,
// and zeroes the configuration registers. A stalled output keeps its beat;
// the input register takes one more beat behind it before in_stall_o rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "admin_session_sequencer_core_assert.svh"

module admin_session_sequencer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ass_pkg::ass_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ass_pkg::ass_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ass_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);
  import ass_pkg::*;

  // Input register stage.
  logic       in_vld_q, in_vld_d;
  ass_in_t    in_q;

  // Result register stage.
  logic       out_vld_q, out_vld_d;
  ass_out_t   out_q;

  // Session state carried from one event beat to the next.
  ass_state_t state_q, state_d;

  ass_cfg_t   cfg;
  ass_out_t   step_res;

  logic       out_free;
  logic       step_fire;
  logic       in_take;

  ass_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ass_step u_step (
    .in_i     (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // The result register can load when it is empty or its beat leaves now.
  assign out_free  = !out_vld_q || !out_stall_i;
  // The buffered event is evaluated and committed when the result can load.
  assign step_fire = in_vld_q && out_free;
  // The input register is free when empty or when its beat moves on.
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_take || (in_vld_q && !step_fire);
  assign out_vld_d = step_fire || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{phase: PH_DISABLED, resp_pending: 1'b0,
                     resp_ready: 1'b0, skip_cmd: 1'b0};
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (step_fire) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step_fire) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A failed request always leaves the session idle and drops the flags
  // that belong to a successful command, response or out-of-date step.
  `ASS_ASSERT_IMPL(a_error_idle, out_vld_q && out_q.flag_error,
    (out_q.session_state == PH_IDLE) && !out_q.flag_cmd_recv &&
    !out_q.flag_rsp_sent && !out_q.flag_out_date,
    "error result with stray flags or non-idle state")

  // The state register follows the phase reported in the newest result.
  `ASS_ASSERT_NEXT(a_state_tracks, step_fire,
    out_q.session_state == state_q.phase,
    "session state register out of step with result")

  // A session that stays disabled asks for nothing and flags nothing.
  `ASS_ASSERT_IMPL(a_disabled_quiet,
    out_vld_q && (out_q.session_state == PH_DISABLED),
    (out_q.action == ACT_NONE) && !out_q.flag_complete && !out_q.flag_error,
    "disabled session produced a request or flag")

  // Input back-pressure only when both stages hold a beat and out stalls.
  `ASS_ASSERT_IMPL(a_stall_full, in_stall_o,
    in_vld_q && out_vld_q && out_stall_i,
    "input stalled while a stage is free")

endmodule

// ----- tb/tb_admin_session_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the admin session sequencer core
// Drives event beats into the sequencer and keeps a cycle-free model of the
// session in step with it. Every result beat is checked field by field
// against the model's answer. The run covers directed sessions, the
// configuration extremes and a long random stream of mostly well-formed
// sessions, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_admin_session_sequencer_core;
  import ass_pkg::*;

  // Register index that maps to no register; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_IDX = 2'd3;

  // The listen request carries this many times the receive length.
  localparam logic [10:0] LISTEN_FACTOR = 11'd5;

  localparam int unsigned MAX_IDLE     = 4;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int unsigned RESET_CYCLES = 12;

  // Status flags of one step, gathered as a mask while the step is modeled.
  localparam logic [6:0] FLG_ERROR     = 7'h01;
  localparam logic [6:0] FLG_COMPLETE  = 7'h02;
  localparam logic [6:0] FLG_TIMEOUT   = 7'h04;
  localparam logic [6:0] FLG_DATA_SENT = 7'h08;
  localparam logic [6:0] FLG_RSP_SENT  = 7'h10;
  localparam logic [6:0] FLG_CMD_RECV  = 7'h20;
  localparam logic [6:0] FLG_OUT_DATE  = 7'h40;

  // Single-event beats; directed steps combine them with a bitwise or.
  localparam ass_in_t EV_INIT    = '{evt_init: 1'b1, default: 1'b0};
  localparam ass_in_t EV_CLOSE   = '{evt_close: 1'b1, default: 1'b0};
  localparam ass_in_t EV_OPEN    = '{evt_open: 1'b1, default: 1'b0};
  localparam ass_in_t EV_READY   = '{evt_resp_ready: 1'b1, default: 1'b0};
  localparam ass_in_t EV_EXPIRED = '{evt_delay_expired: 1'b1, default: 1'b0};
  localparam ass_in_t EV_RECV    = '{evt_recv_done: 1'b1, default: 1'b0};
  localparam ass_in_t EV_SENT    = '{evt_send_done: 1'b1, default: 1'b0};
  localparam ass_in_t EV_TMO     = '{evt_timeout: 1'b1, default: 1'b0};
  localparam ass_in_t EV_BYPASS  = '{set_bypass: 1'b1, default: 1'b0};
  localparam ass_in_t EV_FAIL    = '{service_failed: 1'b1, default: 1'b0};

  // All block inputs start at known values; reset is held from time zero.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  ass_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ass_out_t           out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [7:0]         cfg_data_i  = '0;

  // Model copy of the session state and of the configuration registers.
  phase_e     sess_phase   = PH_DISABLED;
  logic       resp_pending = 1'b0;
  logic       resp_ready   = 1'b0;
  logic       skip_cmd     = 1'b0;
  logic [7:0] rx_delay_r   = 8'd0;
  logic [7:0] rx_length_r  = 8'd0;
  logic [7:0] resp_delay_r = 8'd0;

  // Results that the block still owes, oldest first.
  ass_out_t results_due[$];
  ass_out_t want;

  // Sender and receiver pacing. The sender tracks its own valid so that it
  // never schedules two updates of in_valid_i in one time step.
  bit          valid_up   = 1'b0;
  bit          no_idle    = 1'b0;
  int unsigned stall_left = 0;

  int unsigned mismatches      = 0;
  int unsigned events_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned seen_rsp        = 0;
  int unsigned seen_out_date   = 0;
  int unsigned seen_error      = 0;
  int unsigned seen_timeout    = 0;

  admin_session_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Session model: one call per accepted event beat. It updates the model
  // state and returns the result beat that the block has to produce.
  // --------------------------------------------------------------------------
  function automatic ass_out_t predict_session_step(ass_in_t ev);
    ass_out_t    res;
    phase_e      prev;
    logic [6:0]  flg;
    action_e     act;
    logic [10:0] secs;
    logic [9:0]  ms;
    logic        failed;
    flg    = '0;
    act    = ACT_NONE;
    secs   = '0;
    ms     = '0;
    failed = 1'b0;

    // Init acts first and counts as the phase the step started from.
    if (ev.evt_init) begin
      resp_pending = 1'b0;
      resp_ready   = 1'b0;
      sess_phase   = PH_IDLE;
    end
    prev = sess_phase;
    if (ev.set_bypass) skip_cmd = 1'b1;

    // Close asks for a timer stop, which any later request replaces.
    if (ev.evt_close) begin
      act        = ACT_STOP_TIMER;
      sess_phase = PH_IDLE;
      flg        = FLG_COMPLETE;
    end
    if (ev.evt_resp_ready) resp_ready = 1'b1;

    // A failed request keeps its action but drops every earlier flag and
    // sends the session back to idle.
    case (sess_phase)
      PH_IDLE: begin
        if (ev.evt_open) begin
          skip_cmd     = 1'b0;
          resp_pending = 1'b0;
          resp_ready   = 1'b0;
          act          = ACT_SEND_DATA;
          ms           = SEND_TIMEOUT_MS;
          if (ev.service_failed) begin
            sess_phase = PH_IDLE;
            flg        = FLG_ERROR;
          end else sess_phase = PH_SENDING;
        end
      end
      PH_WAIT_RX: begin
        if (ev.evt_delay_expired) begin
          if (!skip_cmd) begin
            act  = ACT_LISTEN;
            secs = LISTEN_FACTOR * {3'b000, rx_length_r};
            if (ev.service_failed) begin
              sess_phase = PH_IDLE;
              flg        = FLG_ERROR;
            end else sess_phase = PH_LISTEN;
          end else sess_phase = PH_IDLE;
        end
      end
      PH_LISTEN: begin
        if (ev.evt_recv_done) begin
          flg          = flg | FLG_CMD_RECV;
          resp_pending = 1'b1;
          resp_ready   = 1'b0;
          act          = ACT_START_TIMER;
          if (resp_delay_r != 8'd0) secs = {3'b000, resp_delay_r};
          else ms = ZERO_DLY_WINDOW_MS;
          if (ev.service_failed) begin
            sess_phase = PH_IDLE;
            flg        = FLG_ERROR;
            failed     = 1'b1;
          end else sess_phase = PH_WAIT_TX;
        end
        // A timeout beside a good receive still ends the session.
        if (ev.evt_timeout && !failed) begin
          sess_phase = PH_IDLE;
          flg        = flg | FLG_TIMEOUT;
        end
      end
      PH_WAIT_TX: begin
        if (ev.evt_delay_expired) begin
          if (resp_ready) begin
            act = ACT_SEND_RSP;
            ms  = SEND_TIMEOUT_MS;
            if (ev.service_failed) begin
              sess_phase = PH_IDLE;
              flg        = FLG_ERROR;
            end else sess_phase = PH_SENDING;
          end else begin
            sess_phase = PH_IDLE;
            flg        = flg | FLG_OUT_DATE;
          end
        end
      end
      PH_SENDING: begin
        if (ev.evt_send_done) begin
          if (resp_pending) begin
            sess_phase   = PH_IDLE;
            resp_pending = 1'b0;
            resp_ready   = 1'b0;
            flg          = flg | FLG_RSP_SENT;
          end else begin
            if (!skip_cmd) begin
              act  = ACT_START_TIMER;
              secs = {3'b000, rx_delay_r};
              if (ev.service_failed) begin
                sess_phase = PH_IDLE;
                flg        = FLG_ERROR;
              end else sess_phase = PH_WAIT_RX;
            end else sess_phase = PH_IDLE;
            // Data sent survives a failure of the timer start after it.
            flg = flg | FLG_DATA_SENT;
          end
        end
        if (ev.evt_timeout) begin
          sess_phase = PH_IDLE;
          flg        = flg | FLG_TIMEOUT;
        end
      end
      default: ;
    endcase

    if (sess_phase != prev && sess_phase == PH_IDLE) flg = flg | FLG_COMPLETE;

    res.flag_error     = |(flg & FLG_ERROR);
    res.flag_complete  = |(flg & FLG_COMPLETE);
    res.flag_timeout   = |(flg & FLG_TIMEOUT);
    res.flag_data_sent = |(flg & FLG_DATA_SENT);
    res.flag_rsp_sent  = |(flg & FLG_RSP_SENT);
    res.flag_cmd_recv  = |(flg & FLG_CMD_RECV);
    res.flag_out_date  = |(flg & FLG_OUT_DATE);
    res.action         = act;
    res.action_seconds = secs;
    res.action_millis  = ms;
    res.session_state  = sess_phase;
    return res;
  endfunction

  function automatic bit one_in(int unsigned n);
    return $urandom_range(n - 1, 0) == 0;
  endfunction

  // Picks the event that moves the session on from the model's phase, with
  // random side events; one beat in five is plain noise over all bits.
  function automatic ass_in_t pick_session_event();
    ass_in_t    ev;
    logic [9:0] raw;
    ev  = '0;
    raw = 10'($urandom_range(1023, 0));
    if (one_in(5)) return ass_in_t'(raw);
    case (sess_phase)
      PH_IDLE:    ev.evt_open = 1'b1;
      PH_WAIT_RX: ev.evt_delay_expired = 1'b1;
      PH_SENDING: begin
        ev.evt_send_done = 1'b1;
        ev.evt_timeout   = one_in(10);
      end
      PH_LISTEN: begin
        if (one_in(8)) ev.evt_timeout = 1'b1;
        else begin
          ev.evt_recv_done = 1'b1;
          ev.evt_timeout   = one_in(10);
        end
      end
      PH_WAIT_TX: begin
        // The application often marks the response ready a step early.
        if (one_in(4)) ev.evt_resp_ready = 1'b1;
        else begin
          ev.evt_delay_expired = 1'b1;
          ev.evt_resp_ready    = !one_in(3);
        end
      end
      default: ev.evt_init = 1'b1;
    endcase
    ev.service_failed = one_in(8);
    ev.set_bypass     = one_in(8);
    ev.evt_resp_ready = ev.evt_resp_ready | one_in(6);
    ev.evt_close      = one_in(40);
    ev.evt_init       = ev.evt_init | one_in(50);
    return ev;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [10:0] got, logic [10:0] want_v);
    if (got !== want_v) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_checked, name, got, want_v));
    end
  endtask

  // --------------------------------------------------------------------------
  // Event channel. The beat stays on the bus until a rising edge finds valid
  // high and stall low; that edge is where the model steps.
  // --------------------------------------------------------------------------
  task automatic send_event(ass_in_t ev);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
    if (gap != 0) begin
      if (valid_up) begin
        in_valid_i <= 1'b0;
        valid_up = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    if (!valid_up) begin
      in_valid_i <= 1'b1;
      valid_up = 1'b1;
    end
    in_data_i <= ev;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    results_due.push_back(predict_session_step(ev));
    events_sent++;
  endtask

  // Holds the event channel quiet until every owed result beat has been
  // taken. It always waits on a clock edge, so valid never drops and rises in
  // one step.
  task automatic wait_for_results();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  // Writes all three registers back to back, optionally preceded by a write
  // to the unused index. The block is drained first so it is idle.
  task automatic program_regs(logic [7:0] rxd, logic [7:0] rxl, logic [7:0] rspd,
                              bit poke_unused);
    logic [CfgIdxW-1:0] idx [4];
    logic [7:0]         val [4];
    int unsigned        first;
    wait_for_results();
    idx[0] = CFG_UNUSED_IDX; val[0] = 8'($urandom_range(255, 0));
    idx[1] = CFG_RX_DELAY;   val[1] = rxd;
    idx[2] = CFG_RX_LENGTH;  val[2] = rxl;
    idx[3] = CFG_RESP_DELAY; val[3] = rspd;
    first  = poke_unused ? 0 : 1;
    for (int unsigned k = first; k < 4; k++) begin
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      if (k == first) cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      case (idx[k])
        CFG_RX_DELAY:   rx_delay_r   = val[k];
        CFG_RX_LENGTH:  rx_length_r  = val[k];
        CFG_RESP_DELAY: resp_delay_r = val[k];
        default: ;
      endcase
      cfg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result channel. Each taken beat is compared with the oldest expectation,
  // then a fresh stall length is drawn for the receiver.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing expected", out_data_o));
      end else begin
        want = results_due.pop_front();
        check_field("flag_error", 11'(out_data_o.flag_error), 11'(want.flag_error));
        check_field("flag_complete", 11'(out_data_o.flag_complete),
                    11'(want.flag_complete));
        check_field("flag_timeout", 11'(out_data_o.flag_timeout),
                    11'(want.flag_timeout));
        check_field("flag_data_sent", 11'(out_data_o.flag_data_sent),
                    11'(want.flag_data_sent));
        check_field("flag_rsp_sent", 11'(out_data_o.flag_rsp_sent),
                    11'(want.flag_rsp_sent));
        check_field("flag_cmd_recv", 11'(out_data_o.flag_cmd_recv),
                    11'(want.flag_cmd_recv));
        check_field("flag_out_date", 11'(out_data_o.flag_out_date),
                    11'(want.flag_out_date));
        check_field("action", 11'(out_data_o.action), 11'(want.action));
        check_field("action_seconds", out_data_o.action_seconds, want.action_seconds);
        check_field("action_millis", 11'(out_data_o.action_millis),
                    11'(want.action_millis));
        check_field("session_state", 11'(out_data_o.session_state),
                    11'(want.session_state));
        results_checked++;
        seen_rsp      += 32'(want.flag_rsp_sent);
        seen_out_date += 32'(want.flag_out_date);
        seen_error    += 32'(want.flag_error);
        seen_timeout  += 32'(want.flag_timeout);
      end
      stall_left = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset the session is disabled: everything but init and close is
  // ignored, a failure with nothing requested included. Close leaves it.
  task automatic test_disabled_phase();
    send_event(EV_OPEN);
    send_event(EV_OPEN | EV_READY | EV_EXPIRED | EV_RECV | EV_SENT | EV_TMO |
               EV_BYPASS | EV_FAIL);
    send_event(EV_CLOSE);
  endtask

  // One complete session with every register at its maximum: data, receive
  // delay, listen, response delay, response.
  task automatic test_full_session();
    program_regs(8'd255, 8'd255, 8'd255, 1'b1);
    send_event(EV_INIT);
    send_event(EV_OPEN);
    send_event(EV_SENT);
    send_event(EV_EXPIRED);
    send_event(EV_RECV);
    send_event(EV_READY);
    send_event(EV_EXPIRED);
    send_event(EV_SENT);
  endtask

  // Registers at zero, so the response delay becomes the short readiness
  // window. Covers receive with timeout, failures, bypass, an out-of-date
  // response and close together with open.
  task automatic test_zero_delays_and_faults();
    program_regs(8'd0, 8'd0, 8'd0, 1'b0);
    send_event(EV_OPEN);
    send_event(EV_SENT);
    send_event(EV_EXPIRED);
    send_event(EV_RECV | EV_TMO);
    send_event(EV_OPEN | EV_FAIL);
    send_event(EV_OPEN);
    send_event(EV_SENT | EV_BYPASS);
    send_event(EV_OPEN);
    send_event(EV_SENT | EV_FAIL);
    send_event(EV_OPEN);
    send_event(EV_SENT);
    send_event(EV_EXPIRED);
    send_event(EV_RECV);
    send_event(EV_EXPIRED);
    send_event(EV_OPEN);
    send_event(EV_CLOSE | EV_OPEN);
    send_event(EV_TMO);
    send_event(EV_FAIL);
  endtask

  // Random sessions over several register settings, the extremes first.
  task automatic test_random_sessions();
    logic [7:0] rxd;
    logic [7:0] rxl;
    logic [7:0] rspd;
    for (int unsigned setting = 0; setting < 6; setting++) begin
      rxd  = 8'($urandom_range(255, 0));
      rxl  = 8'($urandom_range(255, 0));
      rspd = 8'($urandom_range(255, 0));
      case (setting)
        0: begin rxd = 8'd0;   rxl = 8'd0;   rspd = 8'd0;   end
        1: begin rxd = 8'd255; rxl = 8'd255; rspd = 8'd255; end
        2: begin rxd = 8'd255; rxl = 8'd0;   rspd = 8'd0;   end
        3: begin rxd = 8'd0;   rxl = 8'd255; rspd = 8'd1;   end
        default: ;
      endcase
      program_regs(rxd, rxl, rspd, setting == 4);
      repeat (150) send_event(pick_session_event());
    end
  endtask

  // A stretch with no idling on either side, so beats run back to back.
  task automatic test_back_to_back();
    program_regs(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)), 1'b0);
    no_idle = 1'b1;
    repeat (120) send_event(pick_session_event());
    wait_for_results();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled_phase();
    test_full_session();
    test_zero_delays_and_faults();
    test_random_sessions();
    test_back_to_back();

    // Let any stray result beat show up before the verdict.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d event beats, %0d result beats and %0d register writes.",
             events_sent, results_checked, cfg_writes);
    $display("Responses sent %0d, out of date %0d, service errors %0d, timeouts %0d.",
             seen_rsp, seen_out_date, seen_error, seen_timeout);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
